/* hw/rtl/moi_pkg.sv */
// Shared types and constants for the multidimensional index odometer.
`default_nettype none

package moi_pkg;

    localparam int MAX_DIMS   = 8;
    localparam int DIGIT_BITS = 4;
    localparam int FLAT_W     = 33;
    localparam int VAL_W      = 32;
    localparam int BASE_W     = 5;
    localparam int DIMS_W     = 4;
    localparam int POS_W      = 3;
    localparam int PACK_W     = MAX_DIMS * DIGIT_BITS;

    localparam int BASE_MIN = 2;
    localparam int BASE_MAX = 16;

    // division slice: quotient bits produced per cycle
    localparam int SLICE_BITS = 8;
    localparam int SLICES     = VAL_W / SLICE_BITS;
    localparam int SLICE_CW   = $clog2(SLICES);

    localparam logic [0:0] CFG_BASE = 1'b0;
    localparam logic [0:0] CFG_DIMS = 1'b1;

    typedef enum logic [2:0] {
        OP_STEP  = 3'd0,
        OP_CLEAR = 3'd1,
        OP_LOAD  = 3'd2,
        OP_SET   = 3'd3,
        OP_BUMP  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POW,
        ST_EXEC,
        ST_ADJ,
        ST_DIV,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic latch;
        logic pow_step;
        logic exec;
        logic adj;
        logic div_step;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic pow_last;
        logic go_adj;
        logic go_div;
        logic div_last;
    } t_stat;

endpackage

`default_nettype wire

/* hw/rtl/moi_ctrl.sv */
// Sequencer for the odometer: power loop, execute, adjust or divide, report.
`default_nettype none

module moi_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire moi_pkg::t_stat i_stat,
    output moi_pkg::t_cmd       o_cmd,
    output logic                o_busy,
    output logic                o_strobe
);

    moi_pkg::t_state r_state;
    moi_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= moi_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            moi_pkg::ST_IDLE: begin
                if (i_start) n_state = moi_pkg::ST_POW;
            end
            moi_pkg::ST_POW: begin
                if (i_stat.pow_last) n_state = moi_pkg::ST_EXEC;
            end
            moi_pkg::ST_EXEC: begin
                if (i_stat.go_adj)      n_state = moi_pkg::ST_ADJ;
                else if (i_stat.go_div) n_state = moi_pkg::ST_DIV;
                else                    n_state = moi_pkg::ST_DONE;
            end
            moi_pkg::ST_ADJ: begin
                n_state = moi_pkg::ST_DONE;
            end
            moi_pkg::ST_DIV: begin
                if (i_stat.div_last) n_state = moi_pkg::ST_DONE;
            end
            moi_pkg::ST_DONE: begin
                n_state = moi_pkg::ST_IDLE;
            end
            default: begin
                n_state = moi_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd    = '0;
        o_busy   = 1'b1;
        o_strobe = 1'b0;
        case (r_state)
            moi_pkg::ST_IDLE: begin
                o_busy      = 1'b0;
                o_cmd.latch = i_start;
            end
            moi_pkg::ST_POW:  o_cmd.pow_step = 1'b1;
            moi_pkg::ST_EXEC: o_cmd.exec     = 1'b1;
            moi_pkg::ST_ADJ:  o_cmd.adj      = 1'b1;
            moi_pkg::ST_DIV:  o_cmd.div_step = 1'b1;
            moi_pkg::ST_DONE: o_strobe       = 1'b1;
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/moi_dp.sv */
// Odometer datapath: config, digits, flat position, power multiplier, divider.
`default_nettype none

module moi_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [0:0]                         i_cfg_idx,
    input  wire logic [moi_pkg::BASE_W-1:0]         i_cfg_wdata,
    input  wire logic [2:0]                         i_opcode,
    input  wire logic [moi_pkg::VAL_W-1:0]          i_flat_value,
    input  wire logic [moi_pkg::POS_W-1:0]          i_digit_pos,
    input  wire logic [moi_pkg::DIGIT_BITS-1:0]     i_digit_value,
    input  wire moi_pkg::t_cmd                      i_cmd,
    output moi_pkg::t_stat                          o_stat,
    output logic [moi_pkg::FLAT_W-1:0]              o_flat_position,
    output logic [moi_pkg::PACK_W-1:0]              o_digits_packed,
    output logic                                    o_at_end,
    output logic                                    o_op_error
);

    localparam int DB = moi_pkg::DIGIT_BITS;
    localparam int FW = moi_pkg::FLAT_W;
    localparam int VW = moi_pkg::VAL_W;
    localparam int BW = moi_pkg::BASE_W;
    localparam int DW = moi_pkg::DIMS_W;
    localparam int PW = moi_pkg::POS_W;
    localparam int SB = moi_pkg::SLICE_BITS;
    localparam int SC = moi_pkg::SLICE_CW;

    // raw config registers
    logic [BW-1:0] r_base;
    logic [DW-1:0] r_dims;

    // architectural state
    logic [DB-1:0] r_dig [moi_pkg::MAX_DIMS];
    logic [FW-1:0] r_flat;
    logic          r_err;

    // per-item operands
    logic [BW-1:0] r_b;
    logic [DW-1:0] r_d;
    logic [2:0]    r_op;
    logic [VW-1:0] r_fv;
    logic [PW-1:0] r_pos;
    logic [DB-1:0] r_val;

    // power loop: r_pw ends as base^dims, r_w as base^pos
    logic [FW-1:0] r_pw;
    logic [FW-1:0] r_w;
    logic [PW-1:0] r_k;

    // set/bump adjustment
    logic [FW-1:0] r_adj;
    logic          r_neg;
    logic [DB-1:0] r_newv;

    // divider
    logic [VW-1:0] r_rest;
    logic [DB-1:0] r_rem;
    logic [SC-1:0] r_slice;
    logic [PW-1:0] r_dix;

    logic [BW-1:0]   eff_b;
    logic [DW-1:0]   eff_d;
    logic            at_end;
    logic [DB-1:0]   dig_sel;
    logic            pos_bad;
    logic [DB:0]     bump_v;
    logic [DB-1:0]   newv;
    logic [DB:0]     delta;
    logic [DB-1:0]   mag;
    logic            err_now;
    logic [FW+BW-1:0] pw_prod;
    logic [FW+DB-1:0] adj_prod;
    logic [DB-1:0]   step_dig [moi_pkg::MAX_DIMS];
    logic [DB-1:0]   rem_n;
    logic [SB-1:0]   q_bits;
    logic            slice_last;
    logic            dix_last;

    // clamp config into the usable range
    always_comb begin
        if (r_base < BW'(moi_pkg::BASE_MIN))      eff_b = BW'(moi_pkg::BASE_MIN);
        else if (r_base > BW'(moi_pkg::BASE_MAX)) eff_b = BW'(moi_pkg::BASE_MAX);
        else                                      eff_b = r_base;
        if (r_dims == '0)                         eff_d = DW'(1);
        else if (r_dims > DW'(moi_pkg::MAX_DIMS)) eff_d = DW'(moi_pkg::MAX_DIMS);
        else                                      eff_d = r_dims;
    end

    assign at_end  = (r_flat == r_pw);
    assign dig_sel = r_dig[r_pos];
    assign pos_bad = ({1'b0, r_pos} >= r_d);
    assign bump_v  = {1'b0, dig_sel} + (DB+1)'(1);
    assign newv    = (r_op == moi_pkg::OP_SET) ? r_val : bump_v[DB-1:0];
    assign delta   = {1'b0, newv} - {1'b0, dig_sel};
    assign mag     = delta[DB] ? DB'(-delta) : delta[DB-1:0];
    assign pw_prod  = r_pw * r_b;
    assign adj_prod = r_w * mag;

    always_comb begin
        case (r_op)
            moi_pkg::OP_STEP:  err_now = (r_flat >= r_pw);
            moi_pkg::OP_CLEAR: err_now = 1'b0;
            moi_pkg::OP_LOAD:  err_now = ({1'b0, r_fv} >= r_pw);
            moi_pkg::OP_SET:   err_now = pos_bad || ({1'b0, r_val} >= r_b);
            moi_pkg::OP_BUMP:  err_now = pos_bad || (bump_v >= r_b);
            default:           err_now = 1'b1;
        endcase
    end

    // ripple carry across the digits in use
    always_comb begin
        logic          carry;
        logic [DB:0]   inc;
        carry = 1'b1;
        inc   = '0;
        for (int i = 0; i < moi_pkg::MAX_DIMS; i++) begin
            step_dig[i] = r_dig[i];
            if ((DW'(i) < r_d) && carry) begin
                inc = {1'b0, r_dig[i]} + (DB+1)'(1);
                if (inc == r_b) begin
                    step_dig[i] = '0;
                end else begin
                    step_dig[i] = inc[DB-1:0];
                    carry       = 1'b0;
                end
            end
        end
    end

    // one slice of restoring division by the base; remainder stays below base
    always_comb begin
        logic [DB:0] t;
        logic [DB-1:0] rem;
        rem = r_rem;
        t   = '0;
        for (int j = 0; j < SB; j++) begin
            t = {rem, r_rest[VW-1-j]};
            if (t >= r_b) begin
                rem           = DB'(t - r_b);
                q_bits[SB-1-j] = 1'b1;
            end else begin
                rem           = t[DB-1:0];
                q_bits[SB-1-j] = 1'b0;
            end
        end
        rem_n = rem;
    end

    assign slice_last = (r_slice == SC'(moi_pkg::SLICES - 1));
    assign dix_last   = (({1'b0, r_dix} + DW'(1)) == r_d);

    assign o_stat.pow_last = (({1'b0, r_k} + DW'(1)) == r_d);
    assign o_stat.go_adj   = ((r_op == moi_pkg::OP_SET) || (r_op == moi_pkg::OP_BUMP)) && !err_now;
    assign o_stat.go_div   = (r_op == moi_pkg::OP_LOAD) && !err_now;
    assign o_stat.div_last = slice_last && dix_last;

    // state with reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BW'(moi_pkg::BASE_MIN);
            r_dims <= DW'(1);
            r_flat <= '0;
            r_err  <= 1'b0;
            for (int i = 0; i < moi_pkg::MAX_DIMS; i++) r_dig[i] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                moi_pkg::CFG_BASE: r_base <= i_cfg_wdata;
                moi_pkg::CFG_DIMS: r_dims <= i_cfg_wdata[DW-1:0];
                default:           r_base <= r_base;
            endcase
            r_flat <= '0;
            for (int i = 0; i < moi_pkg::MAX_DIMS; i++) r_dig[i] <= '0;
        end else if (i_cmd.exec) begin
            r_err <= err_now;
            if (!err_now) begin
                case (r_op)
                    moi_pkg::OP_STEP: begin
                        r_flat <= r_flat + FW'(1);
                        for (int i = 0; i < moi_pkg::MAX_DIMS; i++) r_dig[i] <= step_dig[i];
                    end
                    moi_pkg::OP_CLEAR, moi_pkg::OP_LOAD: begin
                        r_flat <= '0;
                        for (int i = 0; i < moi_pkg::MAX_DIMS; i++) r_dig[i] <= '0;
                    end
                    default: begin
                        r_flat <= r_flat;
                    end
                endcase
            end
        end else if (i_cmd.adj) begin
            r_dig[r_pos] <= r_newv;
            // at end all digits are zero and the sum wraps to the adjustment alone
            if (at_end)     r_flat <= r_adj;
            else if (r_neg) r_flat <= r_flat - r_adj;
            else            r_flat <= r_flat + r_adj;
        end else if (i_cmd.div_step && slice_last) begin
            r_dig[r_dix] <= rem_n;
            if (dix_last) r_flat <= {1'b0, r_fv};
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_b   <= eff_b;
            r_d   <= eff_d;
            r_op  <= i_opcode;
            r_fv  <= i_flat_value;
            r_pos <= i_digit_pos;
            r_val <= i_digit_value;
            r_pw  <= FW'(1);
            r_k   <= '0;
        end
        if (i_cmd.pow_step) begin
            if (r_k == r_pos) r_w <= r_pw;
            r_pw <= pw_prod[FW-1:0];
            r_k  <= r_k + PW'(1);
        end
        if (i_cmd.exec) begin
            r_adj   <= adj_prod[FW-1:0];
            r_neg   <= delta[DB];
            r_newv  <= newv;
            r_rest  <= r_fv;
            r_rem   <= '0;
            r_slice <= '0;
            r_dix   <= '0;
        end
        if (i_cmd.div_step) begin
            r_rest  <= {r_rest[VW-SB-1:0], q_bits};
            r_slice <= r_slice + SC'(1);
            if (slice_last) begin
                r_rem <= '0;
                r_dix <= r_dix + PW'(1);
            end else begin
                r_rem <= rem_n;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < moi_pkg::MAX_DIMS; i++) begin
            o_digits_packed[i*DB +: DB] = r_dig[i];
        end
    end

    assign o_flat_position = r_flat;
    assign o_at_end        = at_end;
    assign o_op_error      = r_err;

endmodule

`default_nettype wire

/* hw/rtl/multi_index_odometer.sv */
// Multidimensional index odometer: one digit per dimension plus flat position.
// An accepted word runs the power loop (one base multiply a cycle), then execute;
// a set/bump or load flat that is not refused then adjusts the flat position or
// runs the 8-bit-a-cycle divider for each digit in use, and o_strobe follows.
// A new word can be taken the cycle after o_strobe.
// Reset (synchronous, i_rst_n low): base 2, dims 1, digits and flat position zero.
`default_nettype none

module multi_index_odometer (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // command handshake: word taken when start is high and busy is low
    input  wire logic                               start,
    output logic                                    busy,
    // configuration write port
    input  wire logic                               i_cfg_we,
    input  wire logic [0:0]                         i_cfg_idx,
    input  wire logic [moi_pkg::BASE_W-1:0]         i_cfg_wdata,
    // input word
    input  wire logic [2:0]                         i_opcode,
    input  wire logic [moi_pkg::VAL_W-1:0]          i_flat_value,
    input  wire logic [moi_pkg::POS_W-1:0]          i_digit_pos,
    input  wire logic [moi_pkg::DIGIT_BITS-1:0]     i_digit_value,
    // result word, valid for the single cycle o_strobe is high
    output logic                                    o_strobe,
    output logic [moi_pkg::FLAT_W-1:0]              o_flat_position,
    output logic [moi_pkg::PACK_W-1:0]              o_digits_packed,
    output logic                                    o_at_end,
    output logic                                    o_op_error
);

    moi_pkg::t_cmd  cmd;
    moi_pkg::t_stat stat;

    // Controller: IDLE -> POW -> EXEC -> ADJ | DIV -> DONE, or EXEC -> DONE directly.
    moi_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    // Datapath: holds config, digits and flat position. The power loop builds
    // base^dims (range limit and end marker) and base^pos (weight for set/bump).
    // Set/bump adds weight*(new-old) in one signed step; load splits the value
    // low digit first by repeated division by the base.
    moi_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_opcode        (i_opcode),
        .i_flat_value    (i_flat_value),
        .i_digit_pos     (i_digit_pos),
        .i_digit_value   (i_digit_value),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_flat_position (o_flat_position),
        .o_digits_packed (o_digits_packed),
        .o_at_end        (o_at_end),
        .o_op_error      (o_op_error)
    );

`ifndef NO_ASSERTIONS
    // a taken word makes the block busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // one result per word: each strobe is a lone pulse, low again right after it rises
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("strobe held for more than one cycle");

    // strobe is the last busy cycle, block is free right after
    a_strobe_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy ##1 !busy)
        else $error("strobe not followed by idle");

    // past the last position every digit reads zero
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_at_end) |-> (o_digits_packed == '0))
        else $error("end state with nonzero digits");
`endif

endmodule

`default_nettype wire

/* tb/sv/multi_index_odometer_tb.sv */
// Self-checking testbench for the multidimensional index odometer.
`timescale 1ns / 1ps

module multi_index_odometer_tb;

    localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;  // opcodes from here up are refused
    localparam int PHASES         = 12;
    localparam int PHASE_WORDS    = 90;
    localparam int QUIET_LIMIT    = 2000;  // cycles with no word moving either way
    localparam int TAIL_CYCLES    = 60;    // longer than the longest latency, a load flat with eight digits
    localparam int STEADY_FROM    = 400;   // words in this window are sent without random idle gaps
    localparam int STEADY_TO      = 650;
    localparam int IDLE_PERCENT   = 27;

    typedef enum logic [1:0] {
        ENT_WORD,
        ENT_CFG,
        ENT_PAUSE
    } t_entry_kind;

    typedef struct {
        t_entry_kind                    kind;
        logic [2:0]                     op;
        logic [moi_pkg::VAL_W-1:0]      fv;
        logic [moi_pkg::POS_W-1:0]      pos;
        logic [moi_pkg::DIGIT_BITS-1:0] val;
        logic [0:0]                     idx;
        logic [moi_pkg::BASE_W-1:0]     data;
    } t_entry;

    typedef struct packed {
        logic [moi_pkg::FLAT_W-1:0] flat;
        logic [moi_pkg::PACK_W-1:0] digits;
        logic                       at_end;
        logic                       err;
    } t_odo_word;

    // ---------------------------------------------------------------- DUT I/O
    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic                           i_cfg_we = 1'b0;
    logic [0:0]                     i_cfg_idx = moi_pkg::CFG_BASE;
    logic [moi_pkg::BASE_W-1:0]     i_cfg_wdata = '0;
    logic [2:0]                     i_opcode = moi_pkg::OP_STEP;
    logic [moi_pkg::VAL_W-1:0]      i_flat_value = '0;
    logic [moi_pkg::POS_W-1:0]      i_digit_pos = '0;
    logic [moi_pkg::DIGIT_BITS-1:0] i_digit_value = '0;
    logic                           o_strobe;
    logic [moi_pkg::FLAT_W-1:0]     o_flat_position;
    logic [moi_pkg::PACK_W-1:0]     o_digits_packed;
    logic                           o_at_end;
    logic                           o_op_error;

    multi_index_odometer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_opcode        (i_opcode),
        .i_flat_value    (i_flat_value),
        .i_digit_pos     (i_digit_pos),
        .i_digit_value   (i_digit_value),
        .o_strobe        (o_strobe),
        .o_flat_position (o_flat_position),
        .o_digits_packed (o_digits_packed),
        .o_at_end        (o_at_end),
        .o_op_error      (o_op_error)
    );

    // ------------------------------------------------------- bookkeeping
    t_entry    pending_entries[$];
    t_odo_word expected_odometer_q[$];
    int        words_queued = 0;
    int        words_taken = 0;
    int        results_seen = 0;
    int        err_count = 0;
    int        quiet_cycles = 0;

    // predictor state, reset values of the block
    logic [moi_pkg::BASE_W-1:0]     odo_base = 5'd2;
    logic [moi_pkg::DIMS_W-1:0]     odo_dims = 4'd1;
    logic [moi_pkg::DIGIT_BITS-1:0] odo_digit [moi_pkg::MAX_DIMS];
    logic [moi_pkg::FLAT_W-1:0]     odo_flat = '0;

    // generator-side view of the configuration, tracks what the queue will write
    logic [moi_pkg::BASE_W-1:0]     gen_base = 5'd2;
    logic [moi_pkg::DIMS_W-1:0]     gen_dims = 4'd1;

    initial begin
        foreach (odo_digit[k]) odo_digit[k] = '0;
    end

    // ------------------------------------------------------- predictor
    // out-of-range base and dims clamp to the nearest legal value
    function automatic int unsigned eff_radix(logic [moi_pkg::BASE_W-1:0] r);
        if (r < moi_pkg::BASE_MIN) return moi_pkg::BASE_MIN;
        if (r > moi_pkg::BASE_MAX) return moi_pkg::BASE_MAX;
        return 32'(r);
    endfunction

    function automatic int unsigned eff_width(logic [moi_pkg::DIMS_W-1:0] r);
        if (r == 0) return 1;
        if (r > moi_pkg::MAX_DIMS) return moi_pkg::MAX_DIMS;
        return 32'(r);
    endfunction

    // number of positions, base^dims (at most 2^32)
    function automatic longint unsigned span_of(logic [moi_pkg::BASE_W-1:0] b_reg,
                                                logic [moi_pkg::DIMS_W-1:0] d_reg);
        longint unsigned p;
        int unsigned i;
        p = 1;
        for (i = 0; i < eff_width(d_reg); i++) p = p * eff_radix(b_reg);
        return p;
    endfunction

    function automatic void clear_odometer();
        int i;
        for (i = 0; i < moi_pkg::MAX_DIMS; i++) odo_digit[i] = '0;
        odo_flat = '0;
    endfunction

    // replace one digit; the flat position moves by base^pos times the change
    // and folds back by the span if it lands at or past it (leaves end state)
    function automatic void place_digit(int unsigned pos, int unsigned v,
                                        longint unsigned b, longint unsigned span);
        longint unsigned w, f;
        int unsigned i;
        w = 1;
        for (i = 0; i < pos; i++) w = w * b;
        f = odo_flat + w * v - w * odo_digit[pos];
        if (f >= span) f = f - span;
        odo_flat = moi_pkg::FLAT_W'(f);
        odo_digit[pos] = moi_pkg::DIGIT_BITS'(v);
    endfunction

    function automatic t_odo_word advance_odometer(logic [2:0] op,
                                                   logic [moi_pkg::VAL_W-1:0] fv,
                                                   logic [moi_pkg::POS_W-1:0] pos,
                                                   logic [moi_pkg::DIGIT_BITS-1:0] val);
        t_odo_word r;
        longint unsigned b, span, rest, q;
        int unsigned d, i, nd;
        logic err, carry;
        b = eff_radix(odo_base);
        d = eff_width(odo_dims);
        span = span_of(odo_base, odo_dims);
        err = 1'b0;
        case (op)
            moi_pkg::OP_STEP: begin
                if (odo_flat >= span) begin
                    err = 1'b1;
                end else begin
                    carry = 1'b1;
                    for (i = 0; i < d; i++) begin
                        if (carry) begin
                            nd = odo_digit[i] + 1;
                            if (nd < b) begin
                                odo_digit[i] = moi_pkg::DIGIT_BITS'(nd);
                                carry = 1'b0;
                            end else begin
                                odo_digit[i] = '0;
                            end
                        end
                    end
                    odo_flat = odo_flat + 1'b1;
                end
            end
            moi_pkg::OP_CLEAR: clear_odometer();
            moi_pkg::OP_LOAD: begin
                if (fv >= span) begin
                    err = 1'b1;
                end else begin
                    clear_odometer();
                    rest = 64'(fv);
                    for (i = 0; i < d; i++) begin
                        q = rest / b;
                        odo_digit[i] = moi_pkg::DIGIT_BITS'(rest - q * b);
                        rest = q;
                    end
                    odo_flat = moi_pkg::FLAT_W'(fv);
                end
            end
            moi_pkg::OP_SET: begin
                if (pos >= d || val >= b) err = 1'b1;
                else place_digit(pos, val, b, span);
            end
            moi_pkg::OP_BUMP: begin
                if (pos >= d || odo_digit[pos] + 1 >= b) err = 1'b1;
                else place_digit(pos, odo_digit[pos] + 1, b, span);
            end
            default: err = 1'b1;
        endcase
        for (i = 0; i < moi_pkg::MAX_DIMS; i++)
            r.digits[i*moi_pkg::DIGIT_BITS +: moi_pkg::DIGIT_BITS] = odo_digit[i];
        r.flat   = odo_flat;
        r.at_end = (odo_flat == span);
        r.err    = err;
        return r;
    endfunction

    // ------------------------------------------------------- stimulus helpers
    task automatic push_word(logic [2:0] op, logic [moi_pkg::VAL_W-1:0] fv,
                             logic [moi_pkg::POS_W-1:0] pos,
                             logic [moi_pkg::DIGIT_BITS-1:0] val);
        t_entry e;
        e = '{kind: ENT_WORD, op: op, fv: fv, pos: pos, val: val,
              idx: moi_pkg::CFG_BASE, data: '0};
        pending_entries.push_back(e);
        words_queued++;
    endtask

    task automatic push_cfg(logic [0:0] idx, logic [moi_pkg::BASE_W-1:0] data);
        t_entry e;
        e = '{kind: ENT_CFG, op: moi_pkg::OP_STEP, fv: '0, pos: '0, val: '0, idx: idx,
              data: data};
        pending_entries.push_back(e);
        if (idx == moi_pkg::CFG_BASE) gen_base = data;
        else gen_dims = data[moi_pkg::DIMS_W-1:0];
    endtask

    task automatic push_pause();
        t_entry e;
        e = '{kind: ENT_PAUSE, op: moi_pkg::OP_STEP, fv: '0, pos: '0, val: '0,
              idx: moi_pkg::CFG_BASE, data: '0};
        pending_entries.push_back(e);
    endtask

    // random word, mostly well formed for the configuration in force
    task automatic push_random_word();
        logic [2:0]                     op;
        logic [moi_pkg::VAL_W-1:0]      fv;
        logic [moi_pkg::POS_W-1:0]      pos;
        logic [moi_pkg::DIGIT_BITS-1:0] val;
        int unsigned                    roll, b, d;
        longint unsigned                span;
        b    = eff_radix(gen_base);
        d    = eff_width(gen_dims);
        span = span_of(gen_base, gen_dims);
        fv   = $urandom;
        pos  = 3'($urandom_range(7, 0));
        val  = 4'($urandom_range(15, 0));
        roll = $urandom_range(99, 0);
        if (roll < 38) begin
            op = moi_pkg::OP_STEP;
        end else if (roll < 42) begin
            op = moi_pkg::OP_CLEAR;
        end else if (roll < 57) begin
            op = moi_pkg::OP_LOAD;
            if ($urandom_range(9, 0) < 8) fv = $urandom_range(32'(span - 1), 0);
        end else if (roll < 72) begin
            op = moi_pkg::OP_SET;
            if ($urandom_range(99, 0) < 85) begin
                pos = 3'($urandom_range(d - 1, 0));
                val = 4'($urandom_range(b - 1, 0));
            end
        end else if (roll < 94) begin
            op = moi_pkg::OP_BUMP;
            if ($urandom_range(99, 0) < 85) pos = 3'($urandom_range(d - 1, 0));
        end else begin
            op = OP_FIRST_UNUSED + 3'($urandom_range(2, 0));
        end
        push_word(op, fv, pos, val);
    endtask

    // ------------------------------------------------------- clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------- driver
    // Words go out from the pending queue. A config write or a pause waits
    // until the block is idle and every expected word has come back.
    always @(posedge i_clk) begin : drive_words
        logic   took, nxt_start, nxt_we;
        t_entry e;
        if (!i_rst_n) begin
            start    <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            took      = start && !busy;
            nxt_start = start && !took;  // a word not yet taken stays up
            nxt_we    = 1'b0;
            if (took) begin
                expected_odometer_q.push_back(
                    advance_odometer(i_opcode, i_flat_value, i_digit_pos, i_digit_value));
                words_taken++;
            end
            if (!nxt_start && pending_entries.size() > 0) begin
                e = pending_entries[0];
                if (e.kind == ENT_WORD) begin
                    if ((words_taken >= STEADY_FROM && words_taken < STEADY_TO) ||
                        $urandom_range(99, 0) >= IDLE_PERCENT) begin
                        void'(pending_entries.pop_front());
                        i_opcode      <= e.op;
                        i_flat_value  <= e.fv;
                        i_digit_pos   <= e.pos;
                        i_digit_value <= e.val;
                        nxt_start     = 1'b1;
                    end
                end else if (!took && !busy && expected_odometer_q.size() == 0) begin
                    void'(pending_entries.pop_front());
                    if (e.kind == ENT_CFG) begin
                        nxt_we      = 1'b1;
                        i_cfg_idx   <= e.idx;
                        i_cfg_wdata <= e.data;
                        // any register write also clears the odometer
                        if (e.idx == moi_pkg::CFG_BASE) odo_base = e.data;
                        else odo_dims = e.data[moi_pkg::DIMS_W-1:0];
                        clear_odometer();
                    end
                end
            end
            start    <= nxt_start;
            i_cfg_we <= nxt_we;
        end
    end

    // ------------------------------------------------------- monitor
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: result %0d %s: got 0x%0h, expected 0x%0h",
                 $time, results_seen, what, got, want);
        err_count++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_odo_word want;
        if (i_rst_n && o_strobe) begin
            if (expected_odometer_q.size() == 0) begin
                report_mismatch("arrived with nothing expected", 64'(o_flat_position),
                                64'(0));
            end else begin
                want = expected_odometer_q.pop_front();
                if (o_flat_position !== want.flat)
                    report_mismatch("flat_position", 64'(o_flat_position), 64'(want.flat));
                if (o_digits_packed !== want.digits)
                    report_mismatch("digits_packed", 64'(o_digits_packed),
                                    64'(want.digits));
                if (o_at_end !== want.at_end)
                    report_mismatch("at_end", 64'(o_at_end), 64'(want.at_end));
                if (o_op_error !== want.err)
                    report_mismatch("op_error", 64'(o_op_error), 64'(want.err));
            end
            results_seen++;
        end
    end

    // cycles with no word moving in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------- stimulus and end
    initial begin : run_test
        int                         ph, n;
        logic [moi_pkg::BASE_W-1:0] nb, nd;
        longint unsigned            span;

        // directed: reset config is base 2, one dimension
        push_word(moi_pkg::OP_STEP, '0, '0, '0);
        push_word(moi_pkg::OP_STEP, '0, '0, '0);        // reaches the end
        push_word(moi_pkg::OP_STEP, '0, '0, '0);        // step at end is refused
        push_word(moi_pkg::OP_BUMP, '0, '0, '0);        // bump at end folds back
        push_word(moi_pkg::OP_SET, '0, '0, '0);
        push_word(OP_FIRST_UNUSED, '1, '1, '1);
        push_word(OP_FIRST_UNUSED + 3'd1, '0, '0, '0);
        push_word(OP_FIRST_UNUSED + 3'd2, '0, '0, '0);
        push_word(moi_pkg::OP_CLEAR, '0, '0, '0);

        // widest odometer: span is 2^32
        push_cfg(moi_pkg::CFG_BASE, 5'd16);
        push_cfg(moi_pkg::CFG_DIMS, 5'd8);
        push_word(moi_pkg::OP_LOAD, 32'hFFFF_FFFF, '0, '0);
        push_word(moi_pkg::OP_STEP, '0, '0, '0);        // flat becomes 2^32
        push_word(moi_pkg::OP_SET, '0, 3'd7, 4'd15);    // set at end
        push_word(moi_pkg::OP_BUMP, '0, 3'd7, '0);      // bump past top
        push_word(moi_pkg::OP_SET, '0, 3'd0, 4'd15);
        push_word(moi_pkg::OP_BUMP, '0, 3'd3, '0);
        push_word(moi_pkg::OP_LOAD, '0, '0, '0);

        // base 5, three digits: range checks
        push_cfg(moi_pkg::CFG_BASE, 5'd5);
        push_cfg(moi_pkg::CFG_DIMS, 5'd3);
        push_word(moi_pkg::OP_LOAD, 32'd125, '0, '0);   // load too large
        push_word(moi_pkg::OP_LOAD, 32'd124, '0, '0);
        push_word(moi_pkg::OP_SET, '0, 3'd3, '0);       // unused digit
        push_word(moi_pkg::OP_SET, '0, 3'd0, 4'd5);     // digit value too large
        push_word(moi_pkg::OP_BUMP, '0, 3'd7, '0);

        // register values below and above the legal range clamp
        push_cfg(moi_pkg::CFG_BASE, 5'd0);
        push_cfg(moi_pkg::CFG_DIMS, 5'd0);
        push_word(moi_pkg::OP_STEP, '0, '0, '0);
        push_word(moi_pkg::OP_LOAD, 32'd2, '0, '0);
        push_word(moi_pkg::OP_LOAD, 32'd1, '0, '0);
        push_cfg(moi_pkg::CFG_BASE, 5'd31);
        push_cfg(moi_pkg::CFG_DIMS, 5'd15);
        push_word(moi_pkg::OP_LOAD, 32'h8000_0000, '0, '0);

        // random phases, each under a fresh configuration
        for (ph = 0; ph < PHASES; ph++) begin
            if (ph == 0) begin
                nb = 5'd16;
                nd = 5'd8;
            end else if (ph == 1) begin
                nb = 5'd2;
                nd = 5'd1;
            end else begin
                nb = ($urandom_range(99, 0) < 85)
                     ? 5'($urandom_range(moi_pkg::BASE_MAX, moi_pkg::BASE_MIN))
                     : 5'($urandom_range(31, 0));
                nd = ($urandom_range(99, 0) < 85)
                     ? 5'($urandom_range(moi_pkg::MAX_DIMS, 1))
                     : 5'($urandom_range(31, 0));
            end
            if ($urandom_range(1, 0)) begin
                push_cfg(moi_pkg::CFG_BASE, nb);
                push_cfg(moi_pkg::CFG_DIMS, nd);
            end else begin
                push_cfg(moi_pkg::CFG_DIMS, nd);
                push_cfg(moi_pkg::CFG_BASE, nb);
            end
            n = 0;
            while (n < PHASE_WORDS) begin
                if (n == PHASE_WORDS / 2 && ph % 3 == 2) push_pause();
                if ($urandom_range(99, 0) < 4) begin
                    // land just short of the end, then run into it
                    span = span_of(gen_base, gen_dims);
                    push_word(moi_pkg::OP_LOAD, 32'(span - 2), 3'($urandom_range(7, 0)),
                              4'($urandom_range(15, 0)));
                    repeat (3) push_word(moi_pkg::OP_STEP, $urandom,
                                         3'($urandom_range(7, 0)),
                                         4'($urandom_range(15, 0)));
                    n += 4;
                end else begin
                    push_random_word();
                    n++;
                end
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (results_seen < words_queued && quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: %0d of %0d results after %0d quiet cycles",
                     results_seen, words_queued, quiet_cycles);
            $display("multi_index_odometer test failed");
        end else begin
            repeat (TAIL_CYCLES) @(posedge i_clk);
            if (err_count == 0 && expected_odometer_q.size() == 0)
                $display("multi_index_odometer test passed");
            else
                $display("multi_index_odometer test failed");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/moi_pkg.sv
hw/rtl/moi_ctrl.sv
hw/rtl/moi_dp.sv
hw/rtl/multi_index_odometer.sv
tb/sv/multi_index_odometer_tb.sv
